/* rtl/csi_pkg.sv */
// ----------------------------------------------------------------------------
// Coordinated servo interpolator package
// Field widths, request codes and divider sizing shared by the block's files.
// ----------------------------------------------------------------------------
package csi_pkg;

  localparam int AxesDefault = 4;

  localparam int ReqW   = 2;
  localparam int AxisW  = 4;
  localparam int AngW   = 12;
  localparam int TimeW  = 32;
  localparam int SdW    = 16;
  localparam int DistW  = AngW + 1;
  localparam int ProdW  = SdW + DistW;
  localparam int DlyW   = 30;
  localparam int DivW   = 32;
  localparam int ChgW   = DivW + 2;

  localparam int InDataW  = 48;
  localparam int OutDataW = 16;

  localparam logic [SdW-1:0] StepDelayReset = 16'd10;

  localparam logic [ReqW-1:0] ReqInit = 2'd0;
  localparam logic [ReqW-1:0] ReqLoad = 2'd1;
  localparam logic [ReqW-1:0] ReqStep = 2'd2;

endpackage

/* rtl/csi_div.sv */
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses with the result.
// ----------------------------------------------------------------------------
module csi_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [csi_pkg::DivW-1:0] dividend_i,
  input  logic [csi_pkg::DivW-1:0] divisor_i,
  output logic                     done_o,
  output logic [csi_pkg::DivW-1:0] quotient_o
);

  localparam int CntW = $clog2(csi_pkg::DivW);

  logic                     busy_q;
  logic                     done_q;
  logic [CntW-1:0]          cnt_q;
  logic [csi_pkg::DivW-1:0] rem_q;
  logic [csi_pkg::DivW-1:0] quo_q;
  logic [csi_pkg::DivW-1:0] dsr_q;
  logic [csi_pkg::DivW:0]   rem_sh;
  logic                     fits;

  assign rem_sh = {rem_q, quo_q[csi_pkg::DivW-1]};
  assign fits   = (rem_sh >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        if (fits) begin
          rem_q <= csi_pkg::DivW'(rem_sh - {1'b0, dsr_q});
        end else begin
          rem_q <= rem_sh[csi_pkg::DivW-1:0];
        end
        quo_q <= {quo_q[csi_pkg::DivW-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(csi_pkg::DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/coordinated_servo_interpolator.sv */
// ----------------------------------------------------------------------------
// Coordinated servo interpolator
// Multi-axis linear interpolation with per-axis step delays from one shared
// iterative divider.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  s_axis   in         tuser req_type, tdata axis/angle/now_time, tlast last_target
//  m_axis   out        tdata next_angle/axis_moving/any_moving, tuser angle_written
//  cfg      in         step_delay write, always ready
//
//  Init, load and ignored requests go from decode straight to the result. A
//  step without a division passes through S_STEP, and S_APPLY if the axis
//  moves; a dividing step waits in S_SWAIT for the shared divider. A last
//  load walks the axes once for the largest distance, then runs one division
//  per moving axis. Reset is asynchronous, with no clearing pass. The block
//  stalls only when a new result is ready before the last one has been taken.
// ----------------------------------------------------------------------------
module coordinated_servo_interpolator #(
  parameter int AXES = csi_pkg::AxesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // axis [3:0], angle [15:4], now_time [47:16]
  input  logic [csi_pkg::InDataW-1:0]  s_axis_tdata_i,
  // req_type [1:0]
  input  logic [csi_pkg::ReqW-1:0]     s_axis_tuser_i,
  input  logic                         s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // next_angle [11:0], axis_moving [12], any_moving [13], zero [15:14]
  output logic [csi_pkg::OutDataW-1:0] m_axis_tdata_o,
  // angle_written [0]
  output logic [0:0]                   m_axis_tuser_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [csi_pkg::SdW-1:0]      cfg_data_i
);

  localparam int IdxW  = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int AngW  = csi_pkg::AngW;
  localparam int DistW = csi_pkg::DistW;
  localparam int DlyW  = csi_pkg::DlyW;
  localparam int DivW  = csi_pkg::DivW;
  localparam int ChgW  = csi_pkg::ChgW;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MAX, S_MUL, S_SETUP, S_DWAIT, S_FIN,
    S_STEP, S_SWAIT, S_APPLY, S_DONE
  } state_e;

  state_e state_q;

  logic [csi_pkg::SdW-1:0]   step_delay_q;
  logic [csi_pkg::ReqW-1:0]  req_q;
  logic [IdxW-1:0]           idx_q;
  logic                      ax_ok_q;
  logic [AngW-1:0]           ang_q;
  logic [csi_pkg::TimeW-1:0] now_q;
  logic                      last_q;

  logic [AngW-1:0] origin_q  [AXES];
  logic [AngW-1:0] target_q  [AXES];
  logic [AngW-1:0] current_q [AXES];
  logic [DlyW-1:0] delay_q   [AXES];
  logic [AXES-1:0] moving_q;

  logic [csi_pkg::TimeW-1:0] start_time_q;
  logic [DistW-1:0]          largest_q;
  logic [csi_pkg::ProdW-1:0] prod_q;
  logic [ChgW-1:0]           change_q;

  logic [AngW-1:0] res_angle_q;
  logic            res_written_q;
  logic            res_moving_q;

  logic                         out_valid_q;
  logic [csi_pkg::OutDataW-1:0] out_data_q;
  logic                         out_user_q;

  logic [AngW-1:0]  org, tgt, cur;
  logic [DlyW-1:0]  dly;
  logic [DistW-1:0] ld_diff, ld_dist, ax_diff, ax_dist, st_diff, st_dist;
  logic [DlyW-1:0]  dly_mag, dly_wdata;
  logic             dly_we;
  logic [ChgW-1:0]  pos_mag, pos, chg_mag;
  logic             div_start, div_done;
  logic [DivW-1:0]  div_dividend, div_divisor, div_quotient;
  logic [csi_pkg::TimeW-1:0] elapsed;
  logic             last_axis;

  assign org = origin_q[idx_q];
  assign tgt = target_q[idx_q];
  assign cur = current_q[idx_q];
  assign dly = delay_q[idx_q];

  assign ld_diff = {1'b0, ang_q} - {1'b0, org};
  assign ld_dist = ld_diff[DistW-1] ? -ld_diff : ld_diff;
  assign ax_diff = {1'b0, tgt} - {1'b0, org};
  assign ax_dist = ax_diff[DistW-1] ? -ax_diff : ax_diff;
  assign st_diff = {1'b0, tgt} - {1'b0, cur};
  assign st_dist = st_diff[DistW-1] ? -st_diff : st_diff;
  assign dly_mag = dly[DlyW-1] ? -dly : dly;
  assign elapsed = now_q - start_time_q;

  assign pos_mag = ChgW'(div_quotient);
  assign pos     = dly[DlyW-1] ? -pos_mag : pos_mag;
  assign chg_mag = change_q[ChgW-1] ? -change_q : change_q;

  assign last_axis = (idx_q == IdxW'(AXES - 1));

  assign div_start = ((state_q == S_SETUP) && (ax_diff != '0)) ||
                     ((state_q == S_STEP) && (st_diff != '0) && (dly != '0));
  assign div_dividend = (state_q == S_SETUP) ? DivW'(prod_q) : DivW'(elapsed);
  assign div_divisor  = (state_q == S_SETUP) ? DivW'(ax_dist) : DivW'(dly_mag);

  assign dly_we = ((state_q == S_SETUP) && (ax_diff == '0)) ||
                  ((state_q == S_DWAIT) && div_done);
  always_comb begin
    if (state_q == S_SETUP) begin
      dly_wdata = '0;
    end else if (ax_diff[DistW-1]) begin
      dly_wdata = -div_quotient[DlyW-1:0];
    end else begin
      dly_wdata = div_quotient[DlyW-1:0];
    end
  end

  csi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  always_ff @(posedge clk_i) begin
    if (dly_we) begin
      delay_q[idx_q] <= dly_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      step_delay_q  <= csi_pkg::StepDelayReset;
      req_q         <= '0;
      idx_q         <= '0;
      ax_ok_q       <= 1'b0;
      ang_q         <= '0;
      now_q         <= '0;
      last_q        <= 1'b0;
      origin_q      <= '{default: '0};
      target_q      <= '{default: '0};
      current_q     <= '{default: '0};
      moving_q      <= '0;
      start_time_q  <= '0;
      largest_q     <= '0;
      prod_q        <= '0;
      change_q      <= '0;
      res_angle_q   <= '0;
      res_written_q <= 1'b0;
      res_moving_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      out_user_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        step_delay_q <= cfg_data_i;
      end
      if (out_valid_q && m_axis_tready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            req_q         <= s_axis_tuser_i;
            idx_q         <= s_axis_tdata_i[IdxW-1:0];
            ax_ok_q       <= ({1'b0, s_axis_tdata_i[3:0]} < 5'(AXES));
            ang_q         <= s_axis_tdata_i[15:4];
            now_q         <= s_axis_tdata_i[47:16];
            last_q        <= s_axis_tlast_i;
            res_angle_q   <= '0;
            res_written_q <= 1'b0;
            res_moving_q  <= 1'b0;
            state_q       <= S_DECODE;
          end
        end
        S_DECODE: begin
          state_q <= S_DONE;
          if (ax_ok_q) begin
            unique case (req_q)
              csi_pkg::ReqInit: begin
                origin_q[idx_q]  <= ang_q;
                target_q[idx_q]  <= ang_q;
                current_q[idx_q] <= ang_q;
                moving_q[idx_q]  <= 1'b0;
              end
              csi_pkg::ReqLoad: begin
                target_q[idx_q] <= ang_q;
                if (ld_dist > largest_q) begin
                  largest_q <= ld_dist;
                end
                if (last_q) begin
                  idx_q   <= '0;
                  state_q <= S_MAX;
                end
              end
              csi_pkg::ReqStep: begin
                state_q <= S_STEP;
              end
              default: begin
              end
            endcase
          end
        end
        S_MAX: begin
          if (ax_dist > largest_q) begin
            largest_q <= ax_dist;
          end
          if (last_axis) begin
            state_q <= S_MUL;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_MUL: begin
          prod_q  <= step_delay_q * largest_q;
          idx_q   <= '0;
          state_q <= S_SETUP;
        end
        S_SETUP: begin
          if (ax_diff == '0) begin
            moving_q[idx_q] <= 1'b0;
            if (last_axis) begin
              state_q <= S_FIN;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end else begin
            state_q <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            moving_q[idx_q] <= 1'b1;
            if (last_axis) begin
              state_q <= S_FIN;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_SETUP;
            end
          end
        end
        S_FIN: begin
          start_time_q <= now_q;
          largest_q    <= '0;
          state_q      <= S_DONE;
        end
        S_STEP: begin
          if (st_diff == '0) begin
            moving_q[idx_q] <= 1'b0;
            state_q         <= S_DONE;
          end else begin
            res_moving_q <= 1'b1;
            if (dly == '0) begin
              change_q <= ChgW'(signed'(st_diff));
              state_q  <= S_APPLY;
            end else begin
              state_q <= S_SWAIT;
            end
          end
        end
        S_SWAIT: begin
          if (div_done) begin
            change_q <= pos + ChgW'(org) - ChgW'(cur);
            state_q  <= S_APPLY;
          end
        end
        S_APPLY: begin
          moving_q[idx_q] <= 1'b1;
          if (change_q != '0) begin
            res_written_q <= 1'b1;
            if (chg_mag < ChgW'(st_dist)) begin
              current_q[idx_q] <= cur + change_q[AngW-1:0];
              res_angle_q      <= cur + change_q[AngW-1:0];
            end else begin
              current_q[idx_q] <= tgt;
              origin_q[idx_q]  <= tgt;
              res_angle_q      <= tgt;
            end
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {2'b00, |moving_q, res_moving_q, res_angle_q};
            out_user_q  <= res_written_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign cfg_ready_o     = 1'b1;

endmodule

/* tb/sv/tb_coordinated_servo_interpolator.sv */
// ----------------------------------------------------------------------------
// Coordinated servo interpolator testbench
// Sends init, load and step requests with random gaps and random output
// stalls, predicts every response with an independent model of the axes, and
// compares each response field by field, across several step delay settings.
// ----------------------------------------------------------------------------
module tb_coordinated_servo_interpolator;
  timeunit 1ns;
  timeprecision 1ps;

  import csi_pkg::*;

  localparam int NumAxes = AxesDefault;
  localparam int StallLimit = 5000;
  localparam int RequestTarget = 1900;
  localparam logic [ReqW-1:0] ReqUnused = 2'd3;
  localparam logic [TimeW-1:0] WrapBase = 32'hFFFF_FFF0;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [AxisW-1:0] axis;
    logic [AngW-1:0]  angle;
    logic [TimeW-1:0] now_time;
    logic             last_target;
  } servo_req_t;

  typedef struct packed {
    logic [AngW-1:0] next_angle;
    logic            angle_written;
    logic            axis_moving;
    logic            any_moving;
  } servo_rsp_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [ReqW-1:0]     s_tuser = '0;
  logic                s_tlast = 1'b0;
  logic                m_tready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [SdW-1:0]      cfg_data = '0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [0:0]          m_axis_tuser_o;
  logic                cfg_ready_o;

  logic [AngW-1:0]    home_angle [NumAxes];
  logic [AngW-1:0]    goal_angle [NumAxes];
  logic [AngW-1:0]    pose_angle [NumAxes];
  longint             tick_delay [NumAxes];
  logic [NumAxes-1:0] axis_busy;
  logic [TimeW-1:0]   move_start;
  longint             widest_move;
  logic [SdW-1:0]     step_delay_ms;

  servo_rsp_t awaited_responses [$];
  int         response_errors = 0;
  int         requests_sent = 0;
  int         rx_hold_cycles = 0;
  bit         tx_gaps_on = 1'b1;
  bit         rx_stalls_on = 1'b1;

  coordinated_servo_interpolator #(
    .AXES(NumAxes)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic servo_rsp_t compute_servo_response(servo_req_t r);
    servo_rsp_t       rsp;
    longint           diff, change, pos, reach, quot;
    logic [TimeW-1:0] elapsed;
    int               ax;
    rsp = '0;
    ax = int'(r.axis);
    if (ax < NumAxes) begin
      case (r.req_type)
        ReqInit: begin
          home_angle[ax] = r.angle;
          goal_angle[ax] = r.angle;
          pose_angle[ax] = r.angle;
          axis_busy[ax] = 1'b0;
        end
        ReqLoad: begin
          goal_angle[ax] = r.angle;
          reach = mag(longint'(r.angle) - longint'(home_angle[ax]));
          if (reach > widest_move) widest_move = reach;
          if (r.last_target) begin
            for (int i = 0; i < NumAxes; i++) begin
              reach = mag(longint'(goal_angle[i]) - longint'(home_angle[i]));
              if (reach > widest_move) widest_move = reach;
            end
            for (int i = 0; i < NumAxes; i++) begin
              diff = longint'(goal_angle[i]) - longint'(home_angle[i]);
              if (diff == 0) begin
                tick_delay[i] = 0;
                axis_busy[i] = 1'b0;
              end else begin
                quot = (longint'(step_delay_ms) * widest_move) / mag(diff);
                tick_delay[i] = (diff < 0) ? -quot : quot;
                axis_busy[i] = 1'b1;
              end
            end
            move_start = r.now_time;
            widest_move = 0;
          end
        end
        ReqStep: begin
          diff = longint'(goal_angle[ax]) - longint'(pose_angle[ax]);
          if (diff != 0) begin
            rsp.axis_moving = 1'b1;
            if (tick_delay[ax] == 0) begin
              change = diff;
            end else begin
              elapsed = r.now_time - move_start;
              pos = longint'(elapsed) / mag(tick_delay[ax]);
              if (tick_delay[ax] < 0) pos = -pos;
              change = pos + longint'(home_angle[ax]) - longint'(pose_angle[ax]);
            end
            if (change != 0) begin
              if (mag(change) < mag(diff)) begin
                pose_angle[ax] = AngW'(longint'(pose_angle[ax]) + change);
              end else begin
                pose_angle[ax] = goal_angle[ax];
                home_angle[ax] = goal_angle[ax];
              end
              rsp.next_angle = pose_angle[ax];
              rsp.angle_written = 1'b1;
            end
          end
          axis_busy[ax] = rsp.axis_moving;
        end
        default: begin
        end
      endcase
    end
    rsp.any_moving = |axis_busy;
    return rsp;
  endfunction

  function automatic int random_pause_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [AngW-1:0] pick_angle(logic [AngW-1:0] base);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return base + AngW'($urandom_range(0, 80)) - AngW'(40);
    if (roll < 85) return AngW'($urandom);
    return base;
  endfunction

  task automatic send_request(logic [ReqW-1:0] kind, int ax, logic [AngW-1:0] ang,
                              logic [TimeW-1:0] now, bit last);
    servo_req_t req;
    int         gap;
    bit         taken;
    gap = tx_gaps_on ? random_pause_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.req_type = kind;
    req.axis = AxisW'(ax);
    req.angle = ang;
    req.now_time = now;
    req.last_target = last;
    s_tdata <= {now, ang, AxisW'(ax)};
    s_tuser <= kind;
    s_tlast <= last;
    s_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      taken = s_axis_tready_o;
      @(posedge clk);
    end while (!taken);
    awaited_responses.push_back(compute_servo_response(req));
    requests_sent++;
  endtask

  task automatic drain_responses();
    s_tvalid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_step_delay(logic [SdW-1:0] value);
    bit taken;
    drain_responses();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = cfg_ready_o;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    step_delay_ms = value;
  endtask

  // One coordinated move: optional re-inits, a target set closed by a last
  // load, then steps at rising times with some noise mixed in.
  task automatic run_random_move();
    int               n_loads, ax, n_steps, roll;
    logic [TimeW-1:0] t0, t, span, hop;
    longint           far;
    for (int a = 0; a < NumAxes; a++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_request(ReqInit, a, AngW'($urandom), $urandom, 1'($urandom));
      end
    end
    n_loads = $urandom_range(1, NumAxes);
    t0 = $urandom;
    for (int k = 0; k < n_loads; k++) begin
      ax = $urandom_range(0, NumAxes - 1);
      if (k == n_loads - 1) send_request(ReqLoad, ax, pick_angle(home_angle[ax]), t0, 1'b1);
      else send_request(ReqLoad, ax, pick_angle(home_angle[ax]), $urandom, 1'b0);
    end
    far = 0;
    for (int a = 0; a < NumAxes; a++) begin
      if (mag(longint'(goal_angle[a]) - longint'(home_angle[a])) > far) begin
        far = mag(longint'(goal_angle[a]) - longint'(home_angle[a]));
      end
    end
    span = TimeW'(longint'(step_delay_ms) * far);
    n_steps = $urandom_range(3, 14);
    hop = span / n_steps * 2 + 1;
    t = t0;
    for (int k = 0; k < n_steps; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_request(2'($urandom), $urandom_range(NumAxes, 15), AngW'($urandom), $urandom,
                     1'($urandom));
      end else if (roll < 5) begin
        send_request(ReqUnused, $urandom_range(0, 15), AngW'($urandom), $urandom,
                     1'($urandom));
      end else if (roll < 8) begin
        ax = $urandom_range(0, NumAxes - 1);
        send_request(ReqLoad, ax, pick_angle(goal_angle[ax]), $urandom, 1'b0);
      end else if (roll < 10) begin
        send_request(ReqInit, $urandom_range(0, NumAxes - 1), AngW'($urandom), $urandom,
                     1'($urandom));
      end else begin
        if (roll < 15) t = $urandom;
        else t = t + TimeW'($urandom_range(0, hop));
        send_request(ReqStep, $urandom_range(0, NumAxes - 1), AngW'($urandom), t,
                     1'($urandom));
      end
    end
    for (int a = 0; a < NumAxes; a++) begin
      if ($urandom_range(0, 1) == 1) begin
        send_request(ReqStep, a, AngW'($urandom),
                     t0 + span + TimeW'($urandom_range(0, span / 4 + 1)), 1'($urandom));
      end
    end
  endtask

  task automatic test_quiet_reset_state();
    send_request(ReqStep, 0, AngW'($urandom), $urandom, 1'b0);
    send_request(ReqUnused, 1, AngW'($urandom), $urandom, 1'b1);
    send_request(ReqStep, 15, AngW'($urandom), $urandom, 1'b0);
    send_request(ReqLoad, 12, AngW'($urandom), $urandom, 1'b1);
  endtask

  task automatic test_directed_motion();
    send_request(ReqInit, 0, 12'd0, $urandom, 1'b0);
    send_request(ReqInit, 1, 12'd4095, $urandom, 1'b0);
    send_request(ReqInit, 2, 12'd2000, $urandom, 1'b0);
    send_request(ReqInit, 3, 12'd777, $urandom, 1'b0);
    send_request(ReqLoad, 0, 12'd4095, $urandom, 1'b0);
    send_request(ReqLoad, 1, 12'd0, $urandom, 1'b0);
    send_request(ReqLoad, 2, 12'd2010, WrapBase, 1'b1);
    send_request(ReqStep, 0, 12'd0, WrapBase, 1'b0);
    send_request(ReqStep, 0, 12'd0, WrapBase + 32'd25, 1'b0);
    send_request(ReqStep, 1, 12'd0, WrapBase + 32'd100, 1'b0);
    send_request(ReqStep, 2, 12'd0, WrapBase + 32'd40950, 1'b0);
    send_request(ReqStep, 3, 12'd0, WrapBase + 32'd40950, 1'b0);
    send_request(ReqStep, 0, 12'd0, WrapBase - 32'd1, 1'b0);
    send_request(ReqStep, 1, 12'd0, WrapBase + 32'd81900, 1'b0);
    send_request(ReqStep, 2, 12'd0, WrapBase + 32'd81900, 1'b0);
    send_request(ReqLoad, 3, 12'd1000, $urandom, 1'b0);
    send_request(ReqStep, 3, 12'd0, $urandom, 1'b0);
    send_request(ReqStep, 1, 12'd0, $urandom, 1'b0);
    // A stale positive delay against a lower target pushes the angle past 4095.
    send_request(ReqInit, 0, 12'd4090, $urandom, 1'b0);
    send_request(ReqLoad, 0, 12'd4095, 32'd1000, 1'b1);
    send_request(ReqLoad, 0, 12'd0, $urandom, 1'b0);
    send_request(ReqStep, 0, 12'd0, 32'd1080, 1'b0);
    send_request(ReqInit, 0, 12'd0, $urandom, 1'b0);
  endtask

  task automatic test_output_backpressure();
    rx_hold_cycles = 300;
    run_random_move();
    run_random_move();
  endtask

  task automatic test_sender_pause();
    run_random_move();
    drain_responses();
    run_random_move();
  endtask

  task automatic test_step_delay_phases();
    logic [SdW-1:0] setting;
    int             goal;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: setting = 16'd1;
        1: setting = 16'hFFFF;
        2: setting = SdW'($urandom_range(2, 12));
        3: setting = SdW'($urandom_range(1, 65535));
        4: setting = SdW'($urandom_range(13, 300));
        default: setting = StepDelayReset;
      endcase
      write_step_delay(setting);
      tx_gaps_on = !(p == 2 || p == 5);
      rx_stalls_on = !(p == 4 || p == 5);
      goal = requests_sent + (RequestTarget - requests_sent) / (6 - p);
      while (requests_sent < goal) run_random_move();
    end
  endtask

  initial begin
    int rx_wait;
    rx_wait = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        m_tready <= 1'b0;
        rx_hold_cycles--;
      end else if (rx_wait > 0) begin
        m_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_tready <= 1'b1;
        if (rx_stalls_on) rx_wait = random_pause_len();
      end
    end
  end

  always @(negedge clk) begin : response_check
    servo_rsp_t got, want;
    if (rst_n && m_axis_tvalid_o && m_tready) begin
      got.next_angle = m_axis_tdata_o[11:0];
      got.axis_moving = m_axis_tdata_o[12];
      got.any_moving = m_axis_tdata_o[13];
      got.angle_written = m_axis_tuser_o[0];
      if (awaited_responses.size() == 0) begin
        response_errors++;
        if (response_errors <= 10) $display("unexpected response %p", got);
      end else begin
        want = awaited_responses.pop_front();
        if (got !== want) begin
          response_errors++;
          if (response_errors <= 10) begin
            $display("response mismatch: next_angle %0d/%0d written %0b/%0b axis_moving %0b/%0b any_moving %0b/%0b (expected/actual)",
                     want.next_angle, got.next_angle, want.angle_written, got.angle_written,
                     want.axis_moving, got.axis_moving, want.any_moving, got.any_moving);
          end
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(negedge clk);
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready) ||
          (cfg_valid && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    for (int i = 0; i < NumAxes; i++) begin
      home_angle[i] = '0;
      goal_angle[i] = '0;
      pose_angle[i] = '0;
      tick_delay[i] = 0;
    end
    axis_busy = '0;
    move_start = '0;
    widest_move = 0;
    step_delay_ms = StepDelayReset;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_quiet_reset_state();
    test_directed_motion();
    test_output_backpressure();
    test_sender_pause();
    test_step_delay_phases();
    drain_responses();
    repeat (200) @(posedge clk);
    if (response_errors == 0 && awaited_responses.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
